>>> rtl/btnrep_pkg.sv
package btnrep_pkg;

   // Width of every button mask field on the request and response channels.
   localparam int FIELD_WIDTH = 12;

   // Width of the delay and period configuration registers.
   localparam int CFG_WIDTH = 16;

   // Width of the configuration register index.
   localparam int CSR_INDEX_WIDTH = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INITIAL_DELAY = 2'd0,
      CSR_REPEAT_PERIOD = 2'd1,
      CSR_INPUT_FREEZE  = 2'd2
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [CFG_WIDTH-1:0] INITIAL_DELAY_RESET = 16'd20;
   localparam logic [CFG_WIDTH-1:0] REPEAT_PERIOD_RESET = 16'd5;

   // Shared control that every lane sees for one request.
   typedef struct packed {
      logic                 update;
      logic [CFG_WIDTH-1:0] initial_delay;
      logic [CFG_WIDTH-1:0] repeat_period;
   } lane_ctrl_type;

   // Control for the merge stage.
   typedef struct packed {
      logic accept;
      logic freeze;
      logic rsp_ready;
   } merge_ctrl_type;

endpackage

>>> rtl/btnrep_if.sv
// Request channel: one sampled button mask.
interface btnrep_req_if
   import btnrep_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] buttons;

   modport source (output valid, output buttons, input ready);
   modport sink   (input valid, input buttons, output ready);
endinterface

// Response channel: the four button masks after one request.
interface btnrep_rsp_if
   import btnrep_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] held_mask;
   logic [FIELD_WIDTH-1:0] pressed_mask;
   logic [FIELD_WIDTH-1:0] released_mask;
   logic [FIELD_WIDTH-1:0] repeat_mask;

   modport source (output valid, output held_mask, output pressed_mask,
                   output released_mask, output repeat_mask, input ready);
   modport sink   (input valid, input held_mask, input pressed_mask,
                   input released_mask, input repeat_mask, output ready);
endinterface

// Configuration write channel.
interface btnrep_csr_if
   import btnrep_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/btnrep_lane.sv
// One button: its repeat down-counter and repeat decision.
module btnrep_lane
   import btnrep_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  logic          held,
   output logic          repeat_hit
);

   logic [COUNTER_WIDTH-1:0] count_ff;
   logic [COUNTER_WIDTH-1:0] count_in;

   // A held button whose counter has run out repeats on this sample.
   assign repeat_hit = held && (count_ff == '0);

   // Released buttons reload the delay, held ones count down, expired ones reload the period.
   always_comb begin
      if (!held) begin
         count_in = ctrl.initial_delay[COUNTER_WIDTH-1:0];
      end else if (count_ff != '0) begin
         count_in = count_ff - COUNTER_WIDTH'(1);
      end else begin
         count_in = ctrl.repeat_period[COUNTER_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.update) begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/btnrep_merge.sv
// Combines the lane results into the four masks and holds the response.
module btnrep_merge
   import btnrep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  merge_ctrl_type         ctrl,
   input  logic [FIELD_WIDTH-1:0] now_mask,
   input  logic [FIELD_WIDTH-1:0] lane_repeat,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] held_mask,
   output logic [FIELD_WIDTH-1:0] pressed_mask,
   output logic [FIELD_WIDTH-1:0] released_mask,
   output logic [FIELD_WIDTH-1:0] repeat_mask
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [FIELD_WIDTH-1:0] held_ff;
   logic [FIELD_WIDTH-1:0] pressed_ff;
   logic [FIELD_WIDTH-1:0] released_ff;
   logic [FIELD_WIDTH-1:0] repeat_ff;
   logic [FIELD_WIDTH-1:0] held_in;
   logic [FIELD_WIDTH-1:0] pressed_in;
   logic [FIELD_WIDTH-1:0] released_in;
   logic [FIELD_WIDTH-1:0] repeat_in;
   logic [FIELD_WIDTH-1:0] diff;

   // Edge masks against the previous held mask.
   assign diff        = now_mask ^ held_ff;
   assign held_in     = now_mask;
   assign pressed_in  = now_mask & diff;
   assign released_in = held_ff & diff;
   assign repeat_in   = pressed_in | lane_repeat;

   // The response is pending from an accepted request until it is taken.
   always_comb begin
      if (ctrl.accept) begin
         valid_in = 1'b1;
      end else if (ctrl.rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // The stored masks double as the response payload; a frozen request
   // leaves them as they are, so the old masks are shown again.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         held_ff     <= '0;
         pressed_ff  <= '0;
         released_ff <= '0;
         repeat_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (ctrl.accept && !ctrl.freeze) begin
            held_ff     <= held_in;
            pressed_ff  <= pressed_in;
            released_ff <= released_in;
            repeat_ff   <= repeat_in;
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign held_mask     = held_ff;
   assign pressed_mask  = pressed_ff;
   assign released_mask = released_ff;
   assign repeat_mask   = repeat_ff;

endmodule

>>> rtl/button_edge_and_auto_repeat_unit.sv
// Channel  Modport  Handshake     Payload
// req_ch   sink     valid, ready  buttons
// rsp_ch   source   valid, ready  held_mask, pressed_mask, released_mask, repeat_mask
// csr_ch   sink     valid, ready  index, data
//
// One request per cycle unless the response stalls: each button lane updates its
// counter as an unfrozen request is accepted; the response appears in the next cycle.
// The response register is the only buffer, so a request is taken whenever
// that register is empty or being emptied in the same cycle.
// Synchronous reset clears all masks, counters and the response valid, and
// loads the configuration reset values. Configuration writes are always taken.
module button_edge_and_auto_repeat_unit
   import btnrep_pkg::*;
#(
   parameter int NUM_BUTTONS   = 12,
   parameter int COUNTER_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   btnrep_req_if.sink   req_ch,
   btnrep_rsp_if.source rsp_ch,
   btnrep_csr_if.sink   csr_ch
);

   // Buttons beyond the mask fields can never be seen, so they get no lane.
   localparam int LANES = (NUM_BUTTONS < FIELD_WIDTH) ? NUM_BUTTONS : FIELD_WIDTH;

   logic [CFG_WIDTH-1:0]   initial_delay_ff;
   logic [CFG_WIDTH-1:0]   repeat_period_ff;
   logic                   input_freeze_ff;
   logic                   req_accept;
   logic                   rsp_valid;
   logic [FIELD_WIDTH-1:0] now_mask;
   logic [FIELD_WIDTH-1:0] lane_repeat;
   lane_ctrl_type          lane_ctrl;
   merge_ctrl_type         merge_ctrl;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff <= INITIAL_DELAY_RESET;
         repeat_period_ff <= REPEAT_PERIOD_RESET;
         input_freeze_ff  <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_INITIAL_DELAY: initial_delay_ff <= csr_ch.data;
            CSR_REPEAT_PERIOD: repeat_period_ff <= csr_ch.data;
            CSR_INPUT_FREEZE:  input_freeze_ff  <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Take a request when the response register is free or being emptied.
   assign req_ch.ready = !rsp_valid || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign lane_ctrl.update        = req_accept && !input_freeze_ff;
   assign lane_ctrl.initial_delay = initial_delay_ff;
   assign lane_ctrl.repeat_period = repeat_period_ff;

   // One lane per button; mask bits without a button stay zero.
   for (genvar b = 0; b < FIELD_WIDTH; b++) begin : g_lane
      if (b < LANES) begin : g_used
         assign now_mask[b] = req_ch.buttons[b];
         btnrep_lane #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (lane_ctrl),
            .held       (now_mask[b]),
            .repeat_hit (lane_repeat[b])
         );
      end else begin : g_unused
         assign now_mask[b]    = 1'b0;
         assign lane_repeat[b] = 1'b0;
      end
   end

   // Merge the lanes into the response masks.
   assign merge_ctrl.accept    = req_accept;
   assign merge_ctrl.freeze    = input_freeze_ff;
   assign merge_ctrl.rsp_ready = rsp_ch.ready;

   btnrep_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (merge_ctrl),
      .now_mask      (now_mask),
      .lane_repeat   (lane_repeat),
      .rsp_valid     (rsp_valid),
      .held_mask     (rsp_ch.held_mask),
      .pressed_mask  (rsp_ch.pressed_mask),
      .released_mask (rsp_ch.released_mask),
      .repeat_mask   (rsp_ch.repeat_mask)
   );

   assign rsp_ch.valid = rsp_valid;

   // A request is never taken while a response waits without being taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(rsp_valid && !rsp_ch.ready))
      else $error("request accepted over a stalled response");

   // A frozen request leaves the masks unchanged.
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && input_freeze_ff) |=>
         ($stable(rsp_ch.held_mask) && $stable(rsp_ch.repeat_mask) &&
          $stable(rsp_ch.pressed_mask) && $stable(rsp_ch.released_mask)))
      else $error("masks changed on a frozen request");

   // Every new press is also reported as a repeat.
   a_press_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ch.pressed_mask & ~rsp_ch.repeat_mask) == '0))
      else $error("press missing from repeat mask");

   // A button cannot be pressed and released in the same sample.
   a_edges_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ch.pressed_mask & rsp_ch.released_mask) == '0))
      else $error("button both pressed and released");

endmodule
